FILE: hw/rtl/sac_pkg.sv
// Shared widths, constants and stage payload types for the shortest-arc
// quaternion unit. Depends on nothing.
`default_nettype none

package sac_pkg;

  // component and lane counts
  localparam int COMP_W = 16;
  localparam int LANES  = 4;

  // front end: squared lengths, their product and its root
  localparam int LEN_W  = 32;
  localparam int PROD_W = 64;
  localparam int NORM_W = PROD_W / 2;
  localparam int DOT_W  = 34;
  localparam int CRS_W  = 33;
  localparam int MAG_W  = 33;

  // opposite-direction test, r * 1e6 < n
  localparam int               OPP_R_W    = 13;
  localparam int               OPP_PROD_W = 33;
  localparam logic [19:0]      OPP_SCALE  = 20'd1000000;

  // normalization
  localparam int POS_W   = 6;
  localparam int NRM_W   = 30;
  localparam int NRM_MSB = 29;
  localparam int SQ_W    = 2 * NRM_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int ROOT_W  = SUM_W / 2;

  // final divide, q = (m * 2^15 + s) / (2 * s)
  localparam int NUM_SHIFT = 15;
  localparam int QUO_W     = 15;
  localparam int DIV_STEPS = QUO_W;
  localparam int NUM_W     = 46;
  localparam int DIV_W     = ROOT_W + 1;

  localparam logic [COMP_W-1:0] Q_ONE = 16'd16384;

  // cross and dot terms plus source vector, carried through the first root
  typedef struct packed {
    logic signed [DOT_W-1:0]  dot;
    logic signed [CRS_W-1:0]  cx;
    logic signed [CRS_W-1:0]  cy;
    logic signed [CRS_W-1:0]  cz;
    logic signed [COMP_W-1:0] ax;
    logic signed [COMP_W-1:0] ay;
    logic signed [COMP_W-1:0] az;
    logic                     zero;
  } geo_t;

  // per-request flags carried to the output
  typedef struct packed {
    logic [LANES-1:0] neg;
    logic             opp;
    logic             zero;
  } flag_t;

  // normalized magnitudes carried through the second root
  typedef struct packed {
    logic [LANES-1:0][NRM_W-1:0] mn;
    flag_t                       fl;
  } norm_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sac_if.sv
// Valid/ready channel interfaces for the shortest-arc quaternion unit.
// Depends on sac_pkg for field widths.
`default_nettype none

interface sac_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [sac_pkg::COMP_W-1:0] from_x;
  logic signed [sac_pkg::COMP_W-1:0] from_y;
  logic signed [sac_pkg::COMP_W-1:0] from_z;
  logic signed [sac_pkg::COMP_W-1:0] to_x;
  logic signed [sac_pkg::COMP_W-1:0] to_y;
  logic signed [sac_pkg::COMP_W-1:0] to_z;

  modport source (output valid, from_x, from_y, from_z, to_x, to_y, to_z, input ready);
  modport sink   (input valid, from_x, from_y, from_z, to_x, to_y, to_z, output ready);
endinterface

interface sac_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [sac_pkg::COMP_W-1:0] quat_x;
  logic signed [sac_pkg::COMP_W-1:0] quat_y;
  logic signed [sac_pkg::COMP_W-1:0] quat_z;
  logic signed [sac_pkg::COMP_W-1:0] quat_w;
  logic                             opposite_case;
  logic                             zero_length;

  modport source (output valid, quat_x, quat_y, quat_z, quat_w, opposite_case, zero_length,
                  input ready);
  modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, opposite_case, zero_length,
                  output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/shortest_arc_quaternion_unit.sv
// Shortest-arc rotation quaternion unit, top level.
// Depends on sac_pkg, sac_if, sac_isqrt and sac_div.
//
// Usage:
//   in_ch carries a request: source vector from_x/y/z and target vector
//   to_x/y/z, signed 16-bit integers. out_ch returns the unit quaternion of
//   the shortest rotation between them in Q1.14 (quat_x/y/z imaginary,
//   quat_w real) plus opposite_case and zero_length flags.
//   Throughput: one request per cycle while out_ch is not stalled.
//   The two integer square roots (32 and 31 stages, one root bit per
//   stage) and the 16-stage rounding divider make up most of the pipeline;
//   the rest is products, sums, squares, the real part, the opposite test,
//   max search, leading-one search, normalizing shift and the output register.
//   Reset: synchronous on rst_n low; all valid bits clear, no request is
//   in flight afterwards and in_ch.ready comes up at once.
//   Stall: while out_ch.valid is high and out_ch.ready is low the whole
//   pipeline holds and in_ch.ready drops; nothing is lost or repeated.
//   A zero-length input gives the identity with zero_length set.
`default_nettype none

module shortest_arc_quaternion_unit (
  input  logic       clk,
  input  logic       rst_n,
  sac_in_if.sink     in_ch,
  sac_out_if.source  out_ch
);

  import sac_pkg::*;

  localparam int PW = 2 * COMP_W;

  // global advance: output register empty or being drained
  logic en;
  logic out_vld_r;

  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // magnitude of a signed value
  function automatic logic [MAG_W-1:0] abs_q(input logic signed [MAG_W:0] v);
    logic signed [MAG_W:0] t;
    t = v[MAG_W] ? -v : v;
    return t[MAG_W-1:0];
  endfunction

  // stage 1: component products
  logic signed [PW-1:0]     sq1_r [6];
  logic signed [PW-1:0]     dp1_r [3];
  logic signed [PW-1:0]     cr1_r [6];
  logic signed [COMP_W-1:0] a1_r  [3];
  logic                     zero1_r;
  logic                     vld1_r;

  logic za, zb;
  assign za = (in_ch.from_x == '0) && (in_ch.from_y == '0) && (in_ch.from_z == '0);
  assign zb = (in_ch.to_x == '0) && (in_ch.to_y == '0) && (in_ch.to_z == '0);

  always_ff @(posedge clk) begin
    if (en) begin
      sq1_r[0] <= in_ch.from_x * in_ch.from_x;
      sq1_r[1] <= in_ch.from_y * in_ch.from_y;
      sq1_r[2] <= in_ch.from_z * in_ch.from_z;
      sq1_r[3] <= in_ch.to_x * in_ch.to_x;
      sq1_r[4] <= in_ch.to_y * in_ch.to_y;
      sq1_r[5] <= in_ch.to_z * in_ch.to_z;
      dp1_r[0] <= in_ch.from_x * in_ch.to_x;
      dp1_r[1] <= in_ch.from_y * in_ch.to_y;
      dp1_r[2] <= in_ch.from_z * in_ch.to_z;
      cr1_r[0] <= in_ch.from_y * in_ch.to_z;
      cr1_r[1] <= in_ch.from_z * in_ch.to_y;
      cr1_r[2] <= in_ch.from_z * in_ch.to_x;
      cr1_r[3] <= in_ch.from_x * in_ch.to_z;
      cr1_r[4] <= in_ch.from_x * in_ch.to_y;
      cr1_r[5] <= in_ch.from_y * in_ch.to_x;
      a1_r[0]  <= in_ch.from_x;
      a1_r[1]  <= in_ch.from_y;
      a1_r[2]  <= in_ch.from_z;
      zero1_r  <= za || zb;
    end
  end

  // stage 2: squared lengths, dot and cross sums
  logic [LEN_W-1:0] la2_r, lb2_r;
  geo_t             geo2_r;
  logic             vld2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      la2_r       <= LEN_W'(sq1_r[0]) + LEN_W'(sq1_r[1]) + LEN_W'(sq1_r[2]);
      lb2_r       <= LEN_W'(sq1_r[3]) + LEN_W'(sq1_r[4]) + LEN_W'(sq1_r[5]);
      geo2_r.dot  <= DOT_W'(dp1_r[0]) + DOT_W'(dp1_r[1]) + DOT_W'(dp1_r[2]);
      geo2_r.cx   <= CRS_W'(cr1_r[0]) - CRS_W'(cr1_r[1]);
      geo2_r.cy   <= CRS_W'(cr1_r[2]) - CRS_W'(cr1_r[3]);
      geo2_r.cz   <= CRS_W'(cr1_r[4]) - CRS_W'(cr1_r[5]);
      geo2_r.ax   <= a1_r[0];
      geo2_r.ay   <= a1_r[1];
      geo2_r.az   <= a1_r[2];
      geo2_r.zero <= zero1_r;
    end
  end

  // stage 3: product of squared lengths
  logic [PROD_W-1:0] prod3_r;
  geo_t              geo3_r;
  logic              vld3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod3_r <= PROD_W'(la2_r) * PROD_W'(lb2_r);
      geo3_r  <= geo2_r;
    end
  end

  // norm term n = floor(sqrt(|a|^2 |b|^2))
  logic              vld_n;
  logic [NORM_W-1:0] n_root;
  geo_t              geo_n;

  sac_isqrt #(
    .IN_W   (PROD_W),
    .SIDE_W ($bits(geo_t))
  ) u_norm_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (vld3_r),
    .rad_i  (prod3_r),
    .side_i (geo3_r),
    .vld_o  (vld_n),
    .root_o (n_root),
    .side_o (geo_n)
  );

  // stage 4: real part r = n + a.b, never below zero
  logic signed [DOT_W:0] r_sum;
  logic [MAG_W-1:0]      r4_r;
  logic [NORM_W-1:0]     n4_r;
  geo_t                  geo4_r;
  logic                  vld4_r;

  assign r_sum = $signed({{(DOT_W + 1 - NORM_W){1'b0}}, n_root}) + (DOT_W + 1)'(geo_n.dot);

  always_ff @(posedge clk) begin
    if (en) begin
      r4_r   <= r_sum[DOT_W] ? '0 : r_sum[MAG_W-1:0];
      n4_r   <= n_root;
      geo4_r <= geo_n;
    end
  end

  // stage 5: r * 1e6 for the opposite test, only small r can pass
  logic [OPP_PROD_W-1:0] oppm5_r;
  logic                  rsmall5_r;
  logic [MAG_W-1:0]      r5_r;
  logic [NORM_W-1:0]     n5_r;
  geo_t                  geo5_r;
  logic                  vld5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      oppm5_r   <= OPP_PROD_W'(r4_r[OPP_R_W-1:0]) * OPP_PROD_W'(OPP_SCALE);
      rsmall5_r <= (r4_r[MAG_W-1:OPP_R_W] == '0);
      r5_r      <= r4_r;
      n5_r      <= n4_r;
      geo5_r    <= geo4_r;
    end
  end

  // stage 6: opposite decision, quaternion select, sign and magnitude
  logic                  opp6;
  logic                  ax_gt;
  logic signed [MAG_W:0] q6 [LANES];
  logic [LANES-1:0][MAG_W-1:0] m6_r;
  flag_t                 fl6_r;
  logic                  vld6_r;

  always_comb begin
    opp6  = rsmall5_r && (oppm5_r < OPP_PROD_W'(n5_r));
    ax_gt = abs_q((MAG_W + 1)'(geo5_r.ax)) > abs_q((MAG_W + 1)'(geo5_r.az));
    if (opp6) begin
      q6[3] = '0;
      if (ax_gt) begin
        q6[0] = -((MAG_W + 1)'(geo5_r.ay));
        q6[1] = (MAG_W + 1)'(geo5_r.ax);
        q6[2] = '0;
      end else begin
        q6[0] = '0;
        q6[1] = -((MAG_W + 1)'(geo5_r.az));
        q6[2] = (MAG_W + 1)'(geo5_r.ay);
      end
    end else begin
      q6[0] = (MAG_W + 1)'(geo5_r.cx);
      q6[1] = (MAG_W + 1)'(geo5_r.cy);
      q6[2] = (MAG_W + 1)'(geo5_r.cz);
      q6[3] = $signed({1'b0, r5_r});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        m6_r[i]      <= abs_q(q6[i]);
        fl6_r.neg[i] <= q6[i][MAG_W];
      end
      fl6_r.opp  <= opp6;
      fl6_r.zero <= geo5_r.zero;
    end
  end

  // stage 7: pairwise max
  logic [MAG_W-1:0]            mx01_7_r, mx23_7_r;
  logic [LANES-1:0][MAG_W-1:0] m7_r;
  flag_t                       fl7_r;
  logic                        vld7_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mx01_7_r <= (m6_r[0] > m6_r[1]) ? m6_r[0] : m6_r[1];
      mx23_7_r <= (m6_r[2] > m6_r[3]) ? m6_r[2] : m6_r[3];
      m7_r     <= m6_r;
      fl7_r    <= fl6_r;
    end
  end

  // stage 8: largest magnitude
  logic [MAG_W-1:0]            mx8_r;
  logic [LANES-1:0][MAG_W-1:0] m8_r;
  flag_t                       fl8_r;
  logic                        vld8_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mx8_r <= (mx01_7_r > mx23_7_r) ? mx01_7_r : mx23_7_r;
      m8_r  <= m7_r;
      fl8_r <= fl7_r;
    end
  end

  // stage 9: leading-one position of the largest magnitude
  logic [POS_W-1:0]            pos8;
  logic [POS_W-1:0]            pos9_r;
  logic [LANES-1:0][MAG_W-1:0] m9_r;
  flag_t                       fl9_r;
  logic                        vld9_r;

  always_comb begin
    pos8 = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (mx8_r[i]) pos8 = POS_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos9_r <= pos8;
      m9_r   <= m8_r;
      fl9_r  <= fl8_r;
    end
  end

  // stage 10: shift so the largest magnitude sits in [2^29, 2^30)
  logic [LANES-1:0][NRM_W-1:0] mn10_r;
  flag_t                       fl10_r;
  logic                        vld10_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        if (pos9_r > POS_W'(NRM_MSB)) begin
          mn10_r[i] <= NRM_W'(m9_r[i] >> (pos9_r - POS_W'(NRM_MSB)));
        end else begin
          mn10_r[i] <= NRM_W'(m9_r[i] << (POS_W'(NRM_MSB) - pos9_r));
        end
      end
      fl10_r <= fl9_r;
    end
  end

  // stage 11: squares
  logic [LANES-1:0][SQ_W-1:0]  sq11_r;
  logic [LANES-1:0][NRM_W-1:0] mn11_r;
  flag_t                       fl11_r;
  logic                        vld11_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        sq11_r[i] <= SQ_W'(mn10_r[i]) * SQ_W'(mn10_r[i]);
      end
      mn11_r <= mn10_r;
      fl11_r <= fl10_r;
    end
  end

  // stage 12: pair sums
  logic [SUM_W-1:0]            s01_12_r, s23_12_r;
  logic [LANES-1:0][NRM_W-1:0] mn12_r;
  flag_t                       fl12_r;
  logic                        vld12_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s01_12_r <= SUM_W'(sq11_r[0]) + SUM_W'(sq11_r[1]);
      s23_12_r <= SUM_W'(sq11_r[2]) + SUM_W'(sq11_r[3]);
      mn12_r   <= mn11_r;
      fl12_r   <= fl11_r;
    end
  end

  // stage 13: sum of squares
  logic [SUM_W-1:0] sum13_r;
  norm_t            nm13_r;
  logic             vld13_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sum13_r   <= s01_12_r + s23_12_r;
      nm13_r.mn <= mn12_r;
      nm13_r.fl <= fl12_r;
    end
  end

  // length of the normalized quaternion
  logic              vld_s;
  logic [ROOT_W-1:0] s_root;
  norm_t             nm_s;

  sac_isqrt #(
    .IN_W   (SUM_W),
    .SIDE_W ($bits(norm_t))
  ) u_len_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (vld13_r),
    .rad_i  (sum13_r),
    .side_i (nm13_r),
    .vld_o  (vld_s),
    .root_o (s_root),
    .side_o (nm_s)
  );

  // rounded division of each lane by the length
  logic                        vld_q;
  logic [LANES-1:0][QUO_W-1:0] quot;
  flag_t                       fl_q;

  sac_div #(
    .SIDE_W ($bits(flag_t))
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (vld_s),
    .mag_i  (nm_s.mn),
    .s_i    (s_root),
    .side_i (nm_s.fl),
    .vld_o  (vld_q),
    .quot_o (quot),
    .side_o (fl_q)
  );

  // valid bits through the local stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r  <= 1'b0;
      vld2_r  <= 1'b0;
      vld3_r  <= 1'b0;
      vld4_r  <= 1'b0;
      vld5_r  <= 1'b0;
      vld6_r  <= 1'b0;
      vld7_r  <= 1'b0;
      vld8_r  <= 1'b0;
      vld9_r  <= 1'b0;
      vld10_r <= 1'b0;
      vld11_r <= 1'b0;
      vld12_r <= 1'b0;
      vld13_r <= 1'b0;
    end else if (en) begin
      vld1_r  <= in_ch.valid;
      vld2_r  <= vld1_r;
      vld3_r  <= vld2_r;
      vld4_r  <= vld_n;
      vld5_r  <= vld4_r;
      vld6_r  <= vld5_r;
      vld7_r  <= vld6_r;
      vld8_r  <= vld7_r;
      vld9_r  <= vld8_r;
      vld10_r <= vld9_r;
      vld11_r <= vld10_r;
      vld12_r <= vld11_r;
      vld13_r <= vld12_r;
    end
  end

  // output register: signs applied, identity for zero-length input
  logic [LANES-1:0][COMP_W-1:0] quat_r;
  logic                         opp_r;
  logic                         zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (fl_q.zero) begin
        quat_r[0] <= '0;
        quat_r[1] <= '0;
        quat_r[2] <= '0;
        quat_r[3] <= Q_ONE;
        opp_r     <= 1'b0;
      end else begin
        for (int i = 0; i < LANES; i++) begin
          quat_r[i] <= fl_q.neg[i] ? (COMP_W'(0) - COMP_W'(quot[i])) : COMP_W'(quot[i]);
        end
        opp_r <= fl_q.opp;
      end
      zero_r <= fl_q.zero;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.quat_x        = quat_r[0];
  assign out_ch.quat_y        = quat_r[1];
  assign out_ch.quat_z        = quat_r[2];
  assign out_ch.quat_w        = quat_r[3];
  assign out_ch.opposite_case = opp_r;
  assign out_ch.zero_length   = zero_r;

endmodule

`default_nettype wire

FILE: hw/rtl/sac_isqrt.sv
// Pipelined integer square root, one result bit per register stage, with a
// sideband word carried alongside. Depends on nothing.
`default_nettype none

module sac_isqrt #(
  parameter int IN_W   = 64,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                vld_i,
  input  logic [IN_W-1:0]     rad_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                vld_o,
  output logic [IN_W/2-1:0]   root_o,
  output logic [SIDE_W-1:0]   side_o
);

  localparam int OUT_W = IN_W / 2;

  logic [IN_W-1:0]   rem_r  [OUT_W];
  logic [OUT_W-1:0]  root_r [OUT_W];
  logic [SIDE_W-1:0] side_r [OUT_W];
  logic              vld_r  [OUT_W];

  for (genvar j = 0; j < OUT_W; j++) begin : g_stage
    localparam int K = OUT_W - 1 - j;
    logic [IN_W-1:0]   rem_in;
    logic [OUT_W-1:0]  root_in;
    logic [SIDE_W-1:0] side_in;
    logic              vld_in;
    logic [IN_W-1:0]   trial;

    // stage input: ports for the first stage, previous stage otherwise
    if (j == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
      assign side_in = side_i;
      assign vld_in  = vld_i;
    end else begin : g_next
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
      assign side_in = side_r[j-1];
      assign vld_in  = vld_r[j-1];
    end

    // trial subtrahend for result bit K
    assign trial = (IN_W'(root_in) << (K + 1)) | (IN_W'(1) << (2 * K));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[j] <= side_in;
        if (rem_in >= trial) begin
          rem_r[j]  <= rem_in - trial;
          root_r[j] <= root_in | (OUT_W'(1) << K);
        end else begin
          rem_r[j]  <= rem_in;
          root_r[j] <= root_in;
        end
      end
    end
  end

  assign vld_o  = vld_r[OUT_W-1];
  assign root_o = root_r[OUT_W-1];
  assign side_o = side_r[OUT_W-1];

endmodule

`default_nettype wire

FILE: hw/rtl/sac_div.sv
// Pipelined restoring divider for the four normalized quaternion lanes,
// rounding to nearest by a shared root. Depends on sac_pkg.
`default_nettype none

module sac_div #(
  parameter int SIDE_W = 1
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           en,
  input  logic                                           vld_i,
  input  logic [sac_pkg::LANES-1:0][sac_pkg::NRM_W-1:0]  mag_i,
  input  logic [sac_pkg::ROOT_W-1:0]                     s_i,
  input  logic [SIDE_W-1:0]                              side_i,
  output logic                                           vld_o,
  output logic [sac_pkg::LANES-1:0][sac_pkg::QUO_W-1:0]  quot_o,
  output logic [SIDE_W-1:0]                              side_o
);

  import sac_pkg::*;

  logic [LANES-1:0][NUM_W-1:0] rem0_r;
  logic [DIV_W-1:0]            d0_r;
  logic [SIDE_W-1:0]           side0_r;
  logic                        vld0_r;

  logic [LANES-1:0][NUM_W-1:0] rem_r  [DIV_STEPS];
  logic [LANES-1:0][QUO_W-1:0] q_r    [DIV_STEPS];
  logic [DIV_W-1:0]            d_r    [DIV_STEPS];
  logic [SIDE_W-1:0]           side_r [DIV_STEPS];
  logic                        vld_r  [DIV_STEPS];

  // numerator m * 2^15 + s and divisor 2 * s
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (en) begin
      vld0_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        rem0_r[i] <= (NUM_W'(mag_i[i]) << NUM_SHIFT) + NUM_W'(s_i);
      end
      d0_r    <= {s_i, 1'b0};
      side0_r <= side_i;
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    localparam int K = DIV_STEPS - 1 - j;
    logic [LANES-1:0][NUM_W-1:0] rem_in;
    logic [LANES-1:0][QUO_W-1:0] q_in;
    logic [DIV_W-1:0]            d_in;
    logic [SIDE_W-1:0]           side_in;
    logic                        vld_in;
    logic [NUM_W-1:0]            trial;

    if (j == 0) begin : g_first
      assign rem_in  = rem0_r;
      assign q_in    = '0;
      assign d_in    = d0_r;
      assign side_in = side0_r;
      assign vld_in  = vld0_r;
    end else begin : g_next
      assign rem_in  = rem_r[j-1];
      assign q_in    = q_r[j-1];
      assign d_in    = d_r[j-1];
      assign side_in = side_r[j-1];
      assign vld_in  = vld_r[j-1];
    end

    assign trial = NUM_W'(d_in) << K;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_in;
      end
    end

    // one quotient bit per lane
    always_ff @(posedge clk) begin
      if (en) begin
        d_r[j]    <= d_in;
        side_r[j] <= side_in;
        for (int i = 0; i < LANES; i++) begin
          if (rem_in[i] >= trial) begin
            rem_r[j][i] <= rem_in[i] - trial;
            q_r[j][i]   <= q_in[i] | (QUO_W'(1) << K);
          end else begin
            rem_r[j][i] <= rem_in[i];
            q_r[j][i]   <= q_in[i];
          end
        end
      end
    end
  end

  assign vld_o  = vld_r[DIV_STEPS-1];
  assign quot_o = q_r[DIV_STEPS-1];
  assign side_o = side_r[DIV_STEPS-1];

endmodule

`default_nettype wire
